// File: hw/rtl/isort_pkg.sv
// isort_pkg: types shared by the insertion sorter cell and its top level
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package isort_pkg;

	localparam int unsigned DataW = 32;

	typedef logic signed [DataW-1:0] data_t;

	// broadcast command to every cell of the chain
	typedef struct packed {
		logic  ins;
		logic  shift;
		data_t value;
	} cmd_t;

	// what a cell shows to its neighbors
	typedef struct packed {
		logic  valid;
		logic  gt;
		data_t value;
	} link_t;

endpackage

`default_nettype wire

// File: hw/rtl/isort_cell.sv
// isort_cell: one storage cell of the insertion chain
// depends on isort_pkg
`timescale 1ns / 1ps
`default_nettype none

module isort_cell (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire isort_pkg::cmd_t  cmd,
	input  wire isort_pkg::link_t prev,
	input  wire isort_pkg::link_t next,
	output isort_pkg::link_t      link_out
);

	logic               valid_q;
	isort_pkg::data_t   value_q;
	logic               gt;
	logic               take;
	isort_pkg::data_t   ins_value;

	assign gt   = valid_q && ($signed(value_q) > $signed(cmd.value));
	assign take = gt || (!valid_q && prev.valid);
	assign ins_value = prev.gt ? prev.value : cmd.value;

	assign link_out.valid = valid_q;
	assign link_out.gt    = gt;
	assign link_out.value = value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.shift) begin
			valid_q <= next.valid;
		end else if (cmd.ins && take) begin
			valid_q <= 1'b1;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			value_q <= next.value;
		end else if (cmd.ins && take) begin
			value_q <= ins_value;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/insertion_sorter.sv
// insertion_sorter: top level, a chain of CAPACITY sorting cells plus drain control
// depends on isort_pkg and isort_cell
`timescale 1ns / 1ps
`default_nettype none

// Usage
// An element is taken at a rising edge with start high and busy low. Each
// taken element is inserted into the chain in that same cycle: every cell
// compares it with its own entry at once and either keeps its entry, takes
// its lower neighbor's entry, or takes the new element. A new element may
// follow in every cycle, so one element per cycle while the set is loading.
// An element that arrives with all CAPACITY cells full is dropped and the
// overflow flag is raised for the set.
// When the element flagged final_item is taken, busy rises on the next
// cycle and the chain drains toward cell 0, one result per cycle, marked by
// strobe, smallest first; end_of_set marks the last one. The first result
// is shown in the cycle after the final element is taken. busy falls right
// after the last result and the block is empty for the next set.
// Results are shown for one cycle only; the receiver cannot stall them.
// Reset empties the chain and clears the overflow flag.
module insertion_sorter #(
	parameter int unsigned CAPACITY = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    start,
	output logic                                         busy,
	input  wire logic signed [isort_pkg::DataW-1:0]      value,
	input  wire logic                                    final_item,
	output logic                                         strobe,
	output logic signed [isort_pkg::DataW-1:0]           sorted_value,
	output logic                                         end_of_set,
	output logic                                         overflow
);

	isort_pkg::link_t lk [CAPACITY];
	isort_pkg::cmd_t  cmd;
	logic             drain_q;
	logic             drop_q;
	logic             accept;
	logic             full;
	logic             last_out;

	assign accept = start && !drain_q;
	assign full   = lk[CAPACITY-1].valid;

	assign cmd.ins   = accept && !full;
	assign cmd.shift = drain_q;
	assign cmd.value = value;

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			isort_pkg::link_t prev_l;
			isort_pkg::link_t next_l;

			if (i == 0) begin : g_first
				assign prev_l = '{valid: 1'b1, gt: 1'b0, value: '0};
			end else begin : g_mid
				assign prev_l = lk[i-1];
			end

			if (i == CAPACITY - 1) begin : g_last
				assign next_l = '{valid: 1'b0, gt: 1'b0, value: '0};
			end else begin : g_inner
				assign next_l = lk[i+1];
			end

			isort_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.cmd      (cmd),
				.prev     (prev_l),
				.next     (next_l),
				.link_out (lk[i])
			);
		end
	endgenerate

	assign last_out     = !lk[1].valid;
	assign busy         = drain_q;
	assign strobe       = drain_q;
	assign sorted_value = lk[0].value;
	assign end_of_set   = drain_q && last_out;
	assign overflow     = drop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q <= 1'b0;
			drop_q  <= 1'b0;
		end else if (drain_q) begin
			if (last_out) begin
				drain_q <= 1'b0;
				drop_q  <= 1'b0;
			end
		end else if (accept) begin
			if (full) begin
				drop_q <= 1'b1;
			end
			if (final_item) begin
				drain_q <= 1'b1;
			end
		end
	end

	a_strobe_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> lk[0].valid)
		else $error("result without stored element");

	a_end_idles: assert property (@(posedge clk) disable iff (!arst_n)
		end_of_set |=> !busy && !lk[0].valid)
		else $error("chain not empty after end of set");

	a_final_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && final_item) |=> busy)
		else $error("final request did not start drain");

	a_overflow_clears: assert property (@(posedge clk) disable iff (!arst_n)
		end_of_set |=> !overflow)
		else $error("overflow flag kept past end of set");

endmodule

`default_nettype wire

// File: test/insertion_sorter_tb.sv
// insertion_sorter_tb: self-checking bench for the insertion sorter, table-driven directed sets
// then random sets, every drained result checked in order against a queue-based sorting model
// depends on isort_pkg and the insertion_sorter rtl
`timescale 1ns / 1ps

module insertion_sorter_tb;

	typedef isort_pkg::data_t data_t;

	localparam int unsigned CAPACITY  = 16;
	localparam int          NumItems  = 410;
	localparam int          QuietFrom = 360;
	localparam int          StallMax  = 1000;
	localparam data_t       MinVal    = 32'sh8000_0000;
	localparam data_t       MaxVal    = 32'sh7fff_ffff;

	typedef struct packed {
		data_t value;
		logic  last;
		logic  dropped;
	} sorted_result_t;

	typedef struct packed {
		logic  typed;
		logic  fin;
		data_t value;
	} request_row_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  start = 1'b0;
	data_t value = '0;
	logic  final_item = 1'b0;
	logic  busy;
	logic  strobe;
	data_t sorted_value;
	logic  end_of_set;
	logic  overflow;

	data_t          held_values[$];
	logic           set_dropped = 1'b0;
	sorted_result_t pending_sorted[$];
	int             err_count = 0;
	int             items_sent = 0;
	int             stall_cycles = 0;

	// typed rows are single-element sets, so the result is the value itself
	request_row_t directed_rows [0:23] = '{
		'{1'b1, 1'b1, MinVal},
		'{1'b1, 1'b1, MaxVal},
		'{1'b0, 1'b0, 32'sd7},
		'{1'b0, 1'b0, MinVal},
		'{1'b0, 1'b0, 32'sd7},
		'{1'b0, 1'b0, MaxVal},
		'{1'b0, 1'b1, -32'sd1},
		'{1'b0, 1'b0, 32'sd40},
		'{1'b0, 1'b0, -32'sd7},
		'{1'b0, 1'b0, 32'sd40},
		'{1'b0, 1'b0, MaxVal},
		'{1'b0, 1'b0, 32'sd3},
		'{1'b0, 1'b0, -32'sd7},
		'{1'b0, 1'b0, MinVal},
		'{1'b0, 1'b0, 32'sd12},
		'{1'b0, 1'b0, 32'sd0},
		'{1'b0, 1'b0, -32'sd1},
		'{1'b0, 1'b0, 32'sd40},
		'{1'b0, 1'b0, 32'sd25},
		'{1'b0, 1'b0, 32'sd1},
		'{1'b0, 1'b0, -32'sd32},
		'{1'b0, 1'b0, MaxVal},
		'{1'b0, 1'b0, 32'sd8},
		'{1'b0, 1'b1, 32'sd5}
	};

	insertion_sorter #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.value       (value),
		.final_item  (final_item),
		.strobe      (strobe),
		.sorted_value(sorted_value),
		.end_of_set  (end_of_set),
		.overflow    (overflow)
	);

	always #1 clk = ~clk;

	task automatic flag_mismatch(input string what, input longint exp, input longint got);
		$display("MISMATCH %s: expected %0d, got %0d at %0t", what, exp, got, $realtime);
		err_count++;
	endtask

	// ascending insert behind equal values; a full store drops and marks the set
	task automatic predict_sorted(input data_t v, input logic fin);
		int             pos;
		sorted_result_t r;
		if (held_values.size() < CAPACITY) begin
			pos = held_values.size();
			while (pos > 0 && held_values[pos-1] > v)
				pos--;
			held_values.insert(pos, v);
		end else begin
			set_dropped = 1'b1;
		end
		if (fin) begin
			foreach (held_values[i]) begin
				r.value   = held_values[i];
				r.last    = (i == held_values.size() - 1);
				r.dropped = set_dropped;
				pending_sorted.push_back(r);
			end
			held_values.delete();
			set_dropped = 1'b0;
		end
	endtask

	task automatic send_request(input data_t v, input logic fin, input logic typed);
		sorted_result_t r;
		start      <= 1'b1;
		value      <= v;
		final_item <= fin;
		do @(posedge clk); while (busy);
		if (typed) begin
			r.value   = v;
			r.last    = 1'b1;
			r.dropped = 1'b0;
			pending_sorted.push_back(r);
			held_values.delete();
			set_dropped = 1'b0;
		end else begin
			predict_sorted(v, fin);
		end
		items_sent++;
	endtask

	task automatic drain_wait();
		start <= 1'b0;
		do @(posedge clk); while (pending_sorted.size() != 0);
	endtask

	// result checking and watchdog
	always @(posedge clk) begin
		sorted_result_t r;
		if (arst_n) begin
			if (strobe) begin
				if (pending_sorted.size() == 0) begin
					flag_mismatch("unexpected result, sorted_value", 0, sorted_value);
				end else begin
					r = pending_sorted.pop_front();
					if (sorted_value !== r.value)
						flag_mismatch("sorted_value", r.value, sorted_value);
					if (end_of_set !== r.last)
						flag_mismatch("end_of_set", r.last, end_of_set);
					if (overflow !== r.dropped)
						flag_mismatch("overflow", r.dropped, overflow);
				end
			end
			if (strobe || (start && !busy)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= StallMax) begin
				$display("watchdog: no activity for %0d cycles", StallMax);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		int    k;
		int    set_len;
		bit    quiet;
		data_t v;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i].value, directed_rows[i].fin, directed_rows[i].typed);
		drain_wait();

		while (items_sent < NumItems) begin
			if ($urandom_range(0, 6) == 0)
				set_len = $urandom_range(CAPACITY + 1, CAPACITY + 6);
			else
				set_len = $urandom_range(1, CAPACITY);
			quiet = ($urandom_range(0, 2) == 0) || (items_sent > QuietFrom);
			if (!quiet && $urandom_range(0, 7) == 0)
				drain_wait();
			for (k = 0; k < set_len; k++) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: v = $urandom;
					5, 6:          v = $signed($urandom_range(0, 15)) - 32'sd8;
					7:             v = MinVal;
					8:             v = MaxVal;
					default:       v = $signed($urandom_range(0, 3)) - 32'sd2;
				endcase
				send_request(v, k == set_len - 1, 1'b0);
				if (!quiet && $urandom_range(0, 3) == 0) begin
					start <= 1'b0;
					repeat ($urandom_range(1, 13)) @(posedge clk);
				end
			end
		end

		drain_wait();
		repeat (CAPACITY + 4) @(posedge clk);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
